### hdl/omnq_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the ordered multiset neighbor query block.
// No dependencies; every other file in hdl/ imports this package.
package omnq_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Word field widths
    localparam int MODE_W   = 2;
    localparam int IO_KEY_W = 16;
    localparam int IO_CNT_W = 7;
    localparam int STAT_W   = 2;

    // Operation modes carried by the input word
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

    // Commands broadcast to the cell row
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [IO_KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic                pred_valid;
        logic [IO_KEY_W-1:0] pred_key;
        logic                succ_valid;
        logic [IO_KEY_W-1:0] succ_key;
        logic                max_valid;
        logic [IO_KEY_W-1:0] max_key;
        logic [IO_CNT_W-1:0] count;
        logic [STAT_W-1:0]   status;
    } out_word_t;

    // Compare flags a cell shows its neighbors and the top level
    typedef struct packed {
        logic lt;   // occupied and key below the compare key
        logic le;   // occupied and key at or below the compare key
        logic eq;   // occupied and key equal to the compare key
    } cell_stat_t;

    // One-hot select flags for the neighbor result
    typedef struct packed {
        logic pred;
        logic succ;
        logic max;
    } cell_sel_t;

endpackage

### hdl/omnq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted key row: holds a key, compares it, shifts on insert/remove.
// Depends on omnq_pkg.
module omnq_cell
    import omnq_pkg::*;
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic             occ,
    input  logic             left_le,
    input  logic [KEY_W-1:0] left_key,
    input  logic             right_lt,
    input  logic             right_occ,
    input  logic [KEY_W-1:0] right_key,
    output logic [KEY_W-1:0] key,
    output cell_stat_t       stat,
    output cell_sel_t        sel
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    // Compare against the broadcast key
    always_comb
    begin
        stat.lt = occ && (key_reg <  cmp_key);
        stat.le = occ && (key_reg <= cmp_key);
        stat.eq = occ && (key_reg == cmp_key);
    end

    // Mark this cell as the predecessor, successor or top of the row
    always_comb
    begin
        sel.pred = stat.lt && !right_lt;
        sel.succ = occ && !stat.le && left_le;
        sel.max  = occ && !right_occ;
    end

    // Hold, take the new key, or shift from a neighbor
    always_comb
    begin
        key_next = key_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (stat.le)
                    key_next = key_reg;
                else if (left_le)
                    key_next = cmp_key;
                else
                    key_next = left_key;
            end
            OP_REMOVE:
            begin
                if (!stat.lt)
                    key_next = right_key;
            end
            default:
                key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

### hdl/omnq_select.sv
`timescale 1ns / 1ps
// Gathers the one-hot select flags of the cell row into the three neighbor keys.
// Depends on omnq_pkg.
module omnq_select
    import omnq_pkg::*;
(
    input  logic [KEY_W-1:0] keys [CAPACITY],
    input  cell_sel_t        sels [CAPACITY],
    output logic             pred_valid,
    output logic [KEY_W-1:0] pred_key,
    output logic             succ_valid,
    output logic [KEY_W-1:0] succ_key,
    output logic             max_valid,
    output logic [KEY_W-1:0] max_key
);

    // AND-OR the selected keys; an empty selection reads as zero
    always_comb
    begin
        pred_valid = 1'b0;
        succ_valid = 1'b0;
        max_valid  = 1'b0;
        pred_key   = '0;
        succ_key   = '0;
        max_key    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pred_valid = pred_valid | sels[i].pred;
            succ_valid = succ_valid | sels[i].succ;
            max_valid  = max_valid  | sels[i].max;
            pred_key   = pred_key | (keys[i] & {KEY_W{sels[i].pred}});
            succ_key   = succ_key | (keys[i] & {KEY_W{sels[i].succ}});
            max_key    = max_key  | (keys[i] & {KEY_W{sels[i].max}});
        end
    end

endmodule

### hdl/ordered_multiset_neighbor_query_top.sv
`timescale 1ns / 1ps
// Top level of the ordered multiset neighbor query block: cell row, control, output word.
// Depends on omnq_pkg, omnq_cell and omnq_select.
//
// The block keeps up to CAPACITY keys in ascending order in a row of cells, one key per
// cell, duplicates allowed. Each input word inserts, removes one copy of, or only queries
// a key, and yields one result word: the nearest stored keys strictly below and above the
// key, the highest stored key and the count, all taken after the operation. At the accepting
// edge every cell compares the key and the row shifts by one place to open or close a gap;
// then, in the query state, every cell compares again and the select network picks the three
// neighbor keys into the output register once that register is free. A new word is accepted
// only in the idle state, after the previous query; a result waiting in the output register
// does not block the next word's insert or remove, only its query cycle.
// After reset the store is empty and ready at once.
module ordered_multiset_neighbor_query_top
    import omnq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_QUERY = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [KEY_W-1:0]    item_key_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_word_t           out_data_reg;
    out_word_t           out_data_next;

    logic                accept;
    logic [KEY_W-1:0]    in_key;
    logic [KEY_W-1:0]    cmp_key;
    cell_op_t            op;
    logic                full;
    logic                found;
    logic                load_out;

    logic [KEY_W-1:0]    keys [CAPACITY];
    cell_stat_t          stats [CAPACITY];
    cell_sel_t           sels [CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] eq_hit;

    logic                pred_valid;
    logic [KEY_W-1:0]    pred_key;
    logic                succ_valid;
    logic [KEY_W-1:0]    succ_key;
    logic                max_valid;
    logic [KEY_W-1:0]    max_key;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_key   = KEY_W'(in_data.key);
    assign cmp_key  = accept ? in_key : item_key_reg;
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign found    = |eq_hit;

    // Build the cell row and its neighbor links
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic             left_le;
            logic [KEY_W-1:0] left_key;
            logic             right_lt;
            logic             right_occ;
            logic [KEY_W-1:0] right_key;

            assign occ[g]    = (CNT_W'(g) < count_reg);
            assign eq_hit[g] = stats[g].eq;

            if (g == 0)
            begin : g_left_end
                assign left_le  = 1'b1;
                assign left_key = keys[g];
            end
            else
            begin : g_left
                assign left_le  = stats[g-1].le;
                assign left_key = keys[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_right_end
                assign right_lt  = 1'b0;
                assign right_occ = 1'b0;
                assign right_key = keys[g];
            end
            else
            begin : g_right
                assign right_lt  = stats[g+1].lt;
                assign right_occ = occ[g+1];
                assign right_key = keys[g+1];
            end

            omnq_cell u_cell (
                .clk       (clk),
                .op        (op),
                .cmp_key   (cmp_key),
                .occ       (occ[g]),
                .left_le   (left_le),
                .left_key  (left_key),
                .right_lt  (right_lt),
                .right_occ (right_occ),
                .right_key (right_key),
                .key       (keys[g]),
                .stat      (stats[g]),
                .sel       (sels[g])
            );
        end
    endgenerate

    omnq_select u_select (
        .keys       (keys),
        .sels       (sels),
        .pred_valid (pred_valid),
        .pred_key   (pred_key),
        .succ_valid (succ_valid),
        .succ_key   (succ_key),
        .max_valid  (max_valid),
        .max_key    (max_key)
    );

    // Decode the accepted word into a row command, a new count and a status
    always_comb
    begin
        op          = OP_HOLD;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = STAT_OK;
            unique case (in_data.mode)
                MODE_INSERT:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else
                    begin
                        op         = OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (found)
                    begin
                        op         = OP_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                        status_next = STAT_ABSENT;
                end
                default:
                    status_next = STAT_OK;
            endcase
        end
    end

    // Load the output word in the query cycle once the register is free
    assign load_out = (state_reg == ST_QUERY) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_data_next            = out_data_reg;
        out_data_next.pred_valid = pred_valid;
        out_data_next.pred_key   = IO_KEY_W'(pred_key);
        out_data_next.succ_valid = succ_valid;
        out_data_next.succ_key   = IO_KEY_W'(succ_key);
        out_data_next.max_valid  = max_valid;
        out_data_next.max_key    = IO_KEY_W'(max_key);
        out_data_next.count      = IO_CNT_W'(count_reg);
        out_data_next.status     = status_reg;
    end

    // Advance the item sequencer and the output handshake
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (out_ready)
                    out_valid_next = 1'b0;
                if (accept)
                    state_next = ST_QUERY;
            end
            ST_QUERY:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item key and status for the query cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            item_key_reg <= in_key;
        status_reg <= status_next;
        if (load_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/omnq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ordered multiset neighbor query block, bound to the top level.
// Depends on omnq_pkg and ordered_multiset_neighbor_query_top.
module omnq_checker
    import omnq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Invalid neighbor fields read as zero
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.pred_valid || out_data.pred_key == '0)
                   && (out_data.succ_valid || out_data.succ_key == '0)
                   && (out_data.max_valid || out_data.max_key == '0))
        else $error("invalid neighbor carries a nonzero key");

    // Top key flag follows the count
    a_max_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.max_valid == (out_data.count != '0))
        else $error("max_valid disagrees with count");

    // The predecessor never lies above the top key and stays below the successor
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pred_valid |->
            out_data.max_valid && out_data.pred_key <= out_data.max_key
            && (!out_data.succ_valid || out_data.pred_key < out_data.succ_key))
        else $error("neighbor keys out of order");

    // A dropped insert only happens at capacity
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STAT_FULL |->
            out_data.count == IO_CNT_W'(CAPACITY))
        else $error("full status below capacity");

endmodule

bind ordered_multiset_neighbor_query_top omnq_checker u_omnq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
